FILE: design/rqvg_pkg.sv
// Shared types, constants and the sine sample function for the rotated quad
// vertex generator. No dependencies; every design file imports this package.

package rqvg_pkg;

   // Default geometry and table size
   localparam int COORD_WIDTH_DEF      = 24;
   localparam int SINE_TABLE_DEPTH_DEF = 256;

   // Fixed field widths
   localparam int COLOR_WIDTH      = 32;
   localparam int TEX_WIDTH        = 16;
   localparam int ANGLE_WIDTH      = 16;
   localparam int ANGLE_FRAC_WIDTH = 14;
   localparam int SINE_WIDTH       = 16;
   localparam int TRIG_WIDTH       = 17;

   // Rotation rounding: products are Q.23, result Q.8
   localparam int PROD_SHIFT = 15;
   localparam int ROUND_BIAS = 1 << 14;

   // Table build constants (Q4.28)
   localparam longint HALF_PI_Q28 = 64'sd421657428;
   localparam longint ONE_Q28     = 64'sd268435456;
   localparam longint SINE_MAX    = 64'sd32767;

   // Corner codes
   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_BR = 2'd3;

   // Angle quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // Per-vertex attributes that ride along the pipeline
   typedef struct packed {
      logic [COLOR_WIDTH-1:0] color;
      logic [TEX_WIDTH-1:0]   tex_u;
      logic [TEX_WIDTH-1:0]   tex_v;
      logic [1:0]             corner;
      logic                   last;
   } attr_type;

   // One quarter-wave sample: Taylor series in Q4.28, scaled to Q1.15
   function automatic logic [SINE_WIDTH-1:0] sine_sample(input longint x);
      longint x2;
      longint term;
      longint sum;
      longint r;
      x2   = (x * x) >>> 28;
      term = x;
      sum  = x;
      term = ((term * x2) >>> 28) / 6;
      sum  = sum - term;
      term = ((term * x2) >>> 28) / 20;
      sum  = sum + term;
      term = ((term * x2) >>> 28) / 42;
      sum  = sum - term;
      term = ((term * x2) >>> 28) / 72;
      sum  = sum + term;
      term = ((term * x2) >>> 28) / 110;
      sum  = sum - term;
      term = ((term * x2) >>> 28) / 156;
      sum  = sum + term;
      term = ((term * x2) >>> 28) / 210;
      sum  = sum - term;
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > ONE_Q28) begin
         sum = ONE_Q28;
      end
      r = (sum * SINE_MAX + (64'sd1 <<< 27)) >>> 28;
      if (r > SINE_MAX) begin
         r = SINE_MAX;
      end
      return r[SINE_WIDTH-1:0];
   endfunction

endpackage

FILE: design/rqvg_rotate.sv
// Rotation datapath: pivot offsets, sin/cos sign selection, four products,
// rounding and saturation. Depends on rqvg_pkg.

module rqvg_rotate #(
   parameter int COORD_WIDTH = rqvg_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  rqvg_pkg::attr_type                in_attr,
   input  logic [1:0]                        in_quad,
   input  logic [rqvg_pkg::SINE_WIDTH-1:0]   in_sin_a,
   input  logic [rqvg_pkg::SINE_WIDTH-1:0]   in_sin_b,
   input  logic signed [COORD_WIDTH:0]       in_x,
   input  logic signed [COORD_WIDTH:0]       in_y,
   input  logic signed [COORD_WIDTH-1:0]     in_px,
   input  logic signed [COORD_WIDTH-1:0]     in_py,
   output logic                              out_valid,
   output rqvg_pkg::attr_type                out_attr,
   output logic signed [COORD_WIDTH-1:0]     out_x,
   output logic signed [COORD_WIDTH-1:0]     out_y
);
   import rqvg_pkg::*;

   localparam int DW = COORD_WIDTH + 2;           // pivot offset
   localparam int PW = DW + TRIG_WIDTH;           // one product
   localparam int SW = PW + 1;                    // difference of products
   localparam int RW = SW - PROD_SHIFT;           // rounded offset
   localparam int VW = RW + 1;                    // offset plus pivot
   localparam logic signed [VW-1:0] SAT_HI =
      $signed({{(VW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

   // Stage 2: offsets from pivot, signed sin and cos
   logic                         s2_valid_ff;
   attr_type                     s2_attr_ff;
   logic signed [DW-1:0]         s2_dx_ff, s2_dy_ff, s2_dx_in, s2_dy_in;
   logic signed [TRIG_WIDTH-1:0] s2_sin_ff, s2_cos_ff, s2_sin_in, s2_cos_in;
   logic signed [COORD_WIDTH-1:0] s2_px_ff, s2_py_ff;

   // Stage 3: products
   logic                         s3_valid_ff;
   attr_type                     s3_attr_ff;
   logic signed [PW-1:0]         s3_xc_ff, s3_ys_ff, s3_xs_ff, s3_yc_ff;
   logic signed [COORD_WIDTH-1:0] s3_px_ff, s3_py_ff;

   // Stage 4: rounded rotated offsets
   logic                         s4_valid_ff;
   attr_type                     s4_attr_ff;
   logic signed [SW-1:0]         s4_sum_x, s4_sum_y;
   logic signed [RW-1:0]         s4_rx_ff, s4_ry_ff, s4_rx_in, s4_ry_in;
   logic signed [COORD_WIDTH-1:0] s4_px_ff, s4_py_ff;

   // Stage 5: output beat
   logic                         s5_valid_ff;
   attr_type                     s5_attr_ff;
   logic signed [VW-1:0]         s5_vx, s5_vy;
   logic signed [COORD_WIDTH-1:0] s5_x_ff, s5_y_ff, s5_x_in, s5_y_in;

   // Offsets and quadrant mapping of the quarter-wave samples
   always_comb begin
      logic signed [TRIG_WIDTH-1:0] a;
      logic signed [TRIG_WIDTH-1:0] b;
      a = $signed({1'b0, in_sin_a});
      b = $signed({1'b0, in_sin_b});
      s2_dx_in = DW'(in_x) - DW'(in_px);
      s2_dy_in = DW'(in_y) - DW'(in_py);
      case (in_quad)
         QUAD_0: begin
            s2_sin_in = a;
            s2_cos_in = b;
         end
         QUAD_1: begin
            s2_sin_in = b;
            s2_cos_in = -a;
         end
         QUAD_2: begin
            s2_sin_in = -a;
            s2_cos_in = -b;
         end
         QUAD_3: begin
            s2_sin_in = -b;
            s2_cos_in = a;
         end
         default: begin
            s2_sin_in = a;
            s2_cos_in = b;
         end
      endcase
   end

   // Round half up and drop to Q.8
   always_comb begin
      s4_sum_x = SW'(s3_xc_ff) - SW'(s3_ys_ff) + SW'(ROUND_BIAS);
      s4_sum_y = SW'(s3_xs_ff) + SW'(s3_yc_ff) + SW'(ROUND_BIAS);
      s4_rx_in = RW'(s4_sum_x >>> PROD_SHIFT);
      s4_ry_in = RW'(s4_sum_y >>> PROD_SHIFT);
   end

   // Add pivot back and clamp to the coordinate range
   always_comb begin
      s5_vx = VW'(s4_rx_ff) + VW'(s4_px_ff);
      s5_vy = VW'(s4_ry_ff) + VW'(s4_py_ff);
      if (s5_vx > SAT_HI) begin
         s5_x_in = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (s5_vx < SAT_LO) begin
         s5_x_in = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         s5_x_in = s5_vx[COORD_WIDTH-1:0];
      end
      if (s5_vy > SAT_HI) begin
         s5_y_in = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (s5_vy < SAT_LO) begin
         s5_y_in = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         s5_y_in = s5_vy[COORD_WIDTH-1:0];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      s2_attr_ff <= in_attr;
      s2_dx_ff   <= s2_dx_in;
      s2_dy_ff   <= s2_dy_in;
      s2_sin_ff  <= s2_sin_in;
      s2_cos_ff  <= s2_cos_in;
      s2_px_ff   <= in_px;
      s2_py_ff   <= in_py;

      s3_attr_ff <= s2_attr_ff;
      s3_xc_ff   <= PW'(s2_dx_ff) * PW'(s2_cos_ff);
      s3_ys_ff   <= PW'(s2_dy_ff) * PW'(s2_sin_ff);
      s3_xs_ff   <= PW'(s2_dx_ff) * PW'(s2_sin_ff);
      s3_yc_ff   <= PW'(s2_dy_ff) * PW'(s2_cos_ff);
      s3_px_ff   <= s2_px_ff;
      s3_py_ff   <= s2_py_ff;

      s4_attr_ff <= s3_attr_ff;
      s4_rx_ff   <= s4_rx_in;
      s4_ry_ff   <= s4_ry_in;
      s4_px_ff   <= s3_px_ff;
      s4_py_ff   <= s3_py_ff;

      s5_attr_ff <= s4_attr_ff;
      s5_x_ff    <= s5_x_in;
      s5_y_ff    <= s5_y_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_attr  = s5_attr_ff;
   assign out_x     = s5_x_ff;
   assign out_y     = s5_y_ff;

endmodule

FILE: design/rotated_quad_vertex_generator_core.sv
// Top level of the rotated quad vertex generator: corner sequencer, sine
// table and corner placement. Depends on rqvg_pkg and rqvg_rotate.
//
// An accepted sprite is registered in the sequencer, and each vertex then
// passes the pipeline stages before it strobes rsp_valid; the other three
// follow on consecutive cycles, as the corner sequencer issues one vertex per
// cycle. busy drops on the cycle the last corner issues, so sprites run
// gap-free. Synchronous reset clears the sequencer and pipeline valid bits;
// the sine table is constant.

module rotated_quad_vertex_generator_core #(
   parameter int SINE_TABLE_DEPTH = rqvg_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int COORD_WIDTH      = rqvg_pkg::COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [rqvg_pkg::COLOR_WIDTH-1:0]   req_sprite_color,
   input  logic signed [COORD_WIDTH-1:0]      req_center_x,
   input  logic signed [COORD_WIDTH-1:0]      req_center_y,
   input  logic [COORD_WIDTH-2:0]             req_quad_width,
   input  logic [COORD_WIDTH-2:0]             req_quad_height,
   input  logic [rqvg_pkg::ANGLE_WIDTH-1:0]   req_angle,
   input  logic signed [COORD_WIDTH-1:0]      req_pivot_x,
   input  logic signed [COORD_WIDTH-1:0]      req_pivot_y,
   input  logic [rqvg_pkg::TEX_WIDTH-1:0]     req_tex_left,
   input  logic [rqvg_pkg::TEX_WIDTH-1:0]     req_tex_top,
   input  logic [rqvg_pkg::TEX_WIDTH-1:0]     req_tex_right,
   input  logic [rqvg_pkg::TEX_WIDTH-1:0]     req_tex_bottom,
   output logic                               rsp_valid,
   output logic [rqvg_pkg::COLOR_WIDTH-1:0]   rsp_vertex_color,
   output logic signed [COORD_WIDTH-1:0]      rsp_vertex_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_vertex_y,
   output logic [rqvg_pkg::TEX_WIDTH-1:0]     rsp_tex_u,
   output logic [rqvg_pkg::TEX_WIDTH-1:0]     rsp_tex_v,
   output logic [1:0]                         rsp_corner,
   output logic                               rsp_last
);
   import rqvg_pkg::*;

   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int IPRD_W = ANGLE_FRAC_WIDTH + IDX_W;
   localparam int HW     = COORD_WIDTH - 2;

   // Quarter-wave sine table, built at elaboration
   logic [SINE_WIDTH-1:0] sine_rom [0:SINE_TABLE_DEPTH];

   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_sine
      localparam longint X_VAL = (HALF_PI_Q28 * longint'(g)) / SINE_TABLE_DEPTH;
      assign sine_rom[g] = sine_sample(X_VAL);
   end

   // Sequencer: holds one sprite and walks its four corners
   logic                          accept;
   logic                          seq_active_ff, seq_active_in;
   logic [1:0]                    seq_corner_ff, seq_corner_in;
   logic [COLOR_WIDTH-1:0]        seq_color_ff;
   logic signed [COORD_WIDTH-1:0] seq_cx_ff, seq_cy_ff, seq_px_ff, seq_py_ff;
   logic [HW-1:0]                 seq_hw_ff, seq_hh_ff;
   logic [TEX_WIDTH-1:0]          seq_tl_ff, seq_tt_ff, seq_tr_ff, seq_tb_ff;
   logic [IDX_W-1:0]              seq_idx_a_ff, seq_idx_b_ff, idx_a_in;
   logic [1:0]                    seq_quad_ff;
   logic [IPRD_W-1:0]             idx_prod;

   assign busy   = seq_active_ff && (seq_corner_ff != CORNER_BR);
   assign accept = start && !busy;

   // Scale the in-quadrant angle to a table index
   assign idx_prod = IPRD_W'(req_angle[ANGLE_FRAC_WIDTH-1:0])
                   * IPRD_W'(SINE_TABLE_DEPTH);
   assign idx_a_in = idx_prod[IPRD_W-1:ANGLE_FRAC_WIDTH];

   // Load on accept, otherwise step corners until the last one issues
   always_comb begin
      seq_active_in = seq_active_ff;
      seq_corner_in = seq_corner_ff;
      if (accept) begin
         seq_active_in = 1'b1;
         seq_corner_in = CORNER_TL;
      end else if (seq_active_ff) begin
         if (seq_corner_ff == CORNER_BR) begin
            seq_active_in = 1'b0;
         end else begin
            seq_corner_in = seq_corner_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_active_ff <= 1'b0;
         seq_corner_ff <= CORNER_TL;
      end else begin
         seq_active_ff <= seq_active_in;
         seq_corner_ff <= seq_corner_in;
      end
   end

   // Hold the sprite beat
   always_ff @(posedge clock) begin
      if (accept) begin
         seq_color_ff <= req_sprite_color;
         seq_cx_ff    <= req_center_x;
         seq_cy_ff    <= req_center_y;
         seq_hw_ff    <= req_quad_width[COORD_WIDTH-2:1];
         seq_hh_ff    <= req_quad_height[COORD_WIDTH-2:1];
         seq_px_ff    <= req_pivot_x;
         seq_py_ff    <= req_pivot_y;
         seq_tl_ff    <= req_tex_left;
         seq_tt_ff    <= req_tex_top;
         seq_tr_ff    <= req_tex_right;
         seq_tb_ff    <= req_tex_bottom;
         seq_idx_a_ff <= idx_a_in;
         seq_idx_b_ff <= IDX_W'(SINE_TABLE_DEPTH) - idx_a_in;
         seq_quad_ff  <= req_angle[ANGLE_WIDTH-1:ANGLE_FRAC_WIDTH];
      end
   end

   // Stage 1: table read, corner placement, texture pick
   logic                          s1_valid_ff;
   attr_type                      s1_attr_ff, s1_attr_in;
   logic [1:0]                    s1_quad_ff;
   logic [SINE_WIDTH-1:0]         s1_sin_a_ff, s1_sin_b_ff;
   logic signed [COORD_WIDTH:0]   s1_x_ff, s1_y_ff, s1_x_in, s1_y_in;
   logic signed [COORD_WIDTH-1:0] s1_px_ff, s1_py_ff;
   logic signed [COORD_WIDTH:0]   half_w, half_h;

   always_comb begin
      half_w = (COORD_WIDTH+1)'($signed({1'b0, seq_hw_ff}));
      half_h = (COORD_WIDTH+1)'($signed({1'b0, seq_hh_ff}));
      if (seq_corner_ff[0]) begin
         s1_x_in = (COORD_WIDTH+1)'(seq_cx_ff) + half_w;
      end else begin
         s1_x_in = (COORD_WIDTH+1)'(seq_cx_ff) - half_w;
      end
      if (seq_corner_ff[1]) begin
         s1_y_in = (COORD_WIDTH+1)'(seq_cy_ff) + half_h;
      end else begin
         s1_y_in = (COORD_WIDTH+1)'(seq_cy_ff) - half_h;
      end
      s1_attr_in.color  = seq_color_ff;
      s1_attr_in.tex_u  = seq_corner_ff[0] ? seq_tr_ff : seq_tl_ff;
      s1_attr_in.tex_v  = seq_corner_ff[1] ? seq_tb_ff : seq_tt_ff;
      s1_attr_in.corner = seq_corner_ff;
      s1_attr_in.last   = (seq_corner_ff == CORNER_BR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= seq_active_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_attr_ff  <= s1_attr_in;
      s1_quad_ff  <= seq_quad_ff;
      s1_sin_a_ff <= sine_rom[seq_idx_a_ff];
      s1_sin_b_ff <= sine_rom[seq_idx_b_ff];
      s1_x_ff     <= s1_x_in;
      s1_y_ff     <= s1_y_in;
      s1_px_ff    <= seq_px_ff;
      s1_py_ff    <= seq_py_ff;
   end

   // Stages 2 to 5: rotate about the pivot
   attr_type out_attr;

   rqvg_rotate #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_attr   (s1_attr_ff),
      .in_quad   (s1_quad_ff),
      .in_sin_a  (s1_sin_a_ff),
      .in_sin_b  (s1_sin_b_ff),
      .in_x      (s1_x_ff),
      .in_y      (s1_y_ff),
      .in_px     (s1_px_ff),
      .in_py     (s1_py_ff),
      .out_valid (rsp_valid),
      .out_attr  (out_attr),
      .out_x     (rsp_vertex_x),
      .out_y     (rsp_vertex_y)
   );

   assign rsp_vertex_color = out_attr.color;
   assign rsp_tex_u        = out_attr.tex_u;
   assign rsp_tex_v        = out_attr.tex_v;
   assign rsp_corner       = out_attr.corner;
   assign rsp_last         = out_attr.last;

   // An accepted sprite starts at its top-left corner next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> seq_active_ff && (seq_corner_ff == CORNER_TL))
      else $error("sprite accept did not start corner walk");

   // Beats of one quad leave on consecutive cycles in corner order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_corner != CORNER_TL) |->
         $past(rsp_valid) && ($past(rsp_corner) == 2'(rsp_corner - 2'd1)))
      else $error("vertex beats out of order or with a gap");

   // last marks exactly the bottom-right corner
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_corner == CORNER_BR)))
      else $error("last flag does not match corner");

   // With no new sprite, the walk ends after the last corner
   assert property (@(posedge clock) disable iff (reset)
      seq_active_ff && (seq_corner_ff == CORNER_BR) && !start |=> !seq_active_ff)
      else $error("sequencer kept running past the last corner");

endmodule
